@@ design/lrb_pkg.sv @@
// shared types, codes and reset constants for the link reconnect backoff supervisor
// no dependencies; used by link_reconnect_backoff_fsm
`default_nettype none

package lrb_pkg;

	// time and register widths
	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_BITS      = 32;
	localparam int SEED_BITS     = 16;
	localparam int IVL_BITS      = 30;
	localparam int ADDR_BITS     = 4;
	localparam int DATA_BITS     = 32;

	// configuration reset values
	localparam logic [SEED_BITS-1:0] SEED_RST  = 16'd2000;
	localparam logic [IVL_BITS-1:0]  CAP_RST   = 30'd130000;
	localparam logic [IVL_BITS-1:0]  CLOSE_RST = 30'd10000;

	// configuration register index (word address)
	typedef enum logic [1:0] {
		CFG_SEED  = 2'd0,
		CFG_CAP   = 2'd1,
		CFG_CLOSE = 2'd2
	} cfg_idx_t;

	// event opcodes
	typedef enum logic [2:0] {
		OP_POLL      = 3'd0,
		OP_START     = 3'd1,
		OP_SESS_UP   = 3'd2,
		OP_SESS_DROP = 3'd3,
		OP_CLOSE_REQ = 3'd4
	} op_t;

	// supervisor states
	typedef enum logic [3:0] {
		ST_OFFLINE      = 4'd0,
		ST_JOIN         = 4'd1,
		ST_WAIT_LINK    = 4'd2,
		ST_CONNECT      = 4'd3,
		ST_WAIT_SESSION = 4'd4,
		ST_SETUP        = 4'd5,
		ST_CONNECTED    = 4'd6,
		ST_CLOSING      = 4'd7,
		ST_CLOSED       = 4'd8
	} state_t;

	// notify codes
	typedef enum logic [2:0] {
		NTF_NONE         = 3'd0,
		NTF_LINK_UP      = 3'd1,
		NTF_LINK_LOST    = 3'd2,
		NTF_SESSION_UP   = 3'd3,
		NTF_SESSION_LOST = 3'd4,
		NTF_CLOSED       = 3'd5
	} notify_t;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [NOW_BITS-1:0] now_ms;
		logic                link_up;
		logic                join_ok;
		logic                connect_ok;
		logic                session_present;
	} req_t;

	typedef struct packed {
		logic [3:0] state_code;
		logic       is_connected;
		logic       do_join;
		logic       do_connect;
		logic       do_graceful_close;
		logic       do_force_close;
		logic [2:0] notify;
		logic       accepted;
		logic       clean_start;
	} rsp_t;

endpackage

`default_nettype wire

@@ design/link_reconnect_backoff_fsm.sv @@
// link join / session connect supervisor with exponential retry backoff
// depends on lrb_pkg for payload structs, state and opcode codes
`default_nettype none

//  channel   direction  handshake               payload
//  req       in         req_valid / req_ready   lrb_pkg::req_t (one event)
//  rsp       out        rsp_valid / rsp_ready   lrb_pkg::rsp_t (one result per event)
//  apb       in / out   psel, penable, pwrite   paddr, pwdata, prdata, pready (always high)
//
//  one request per cycle sustained while rsp_ready keeps up; rsp_valid rises once an accepted request
//  has passed the input register and then the result register, set by the combinational event step
//  the event step (state, stamps, backoff) is resolved when a request leaves the
//  input register, so requests are handled strictly in order
//  arst_n resets state, stamps, retry interval and configuration to their reset values and clears both valid flags
//  a stalled rsp holds the result register; the input register still takes one more request
module link_reconnect_backoff_fsm #(
	parameter int TIME_BITS = lrb_pkg::TIME_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// event requests
	input  wire                               req_valid,
	output logic                              req_ready,
	input  lrb_pkg::req_t                     req,
	// results
	output logic                              rsp_valid,
	input  wire                               rsp_ready,
	output lrb_pkg::rsp_t                     rsp,
	// configuration port
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [lrb_pkg::ADDR_BITS-1:0]     paddr,
	input  wire  [lrb_pkg::DATA_BITS-1:0]     pwdata,
	output logic [lrb_pkg::DATA_BITS-1:0]     prdata,
	output logic                              pready
);

	// compare width wide enough for elapsed time and any interval or timeout
	localparam int CMP_BITS = (TIME_BITS > lrb_pkg::IVL_BITS) ? TIME_BITS : lrb_pkg::IVL_BITS;

	// ---------------- configuration registers ----------------
	logic [lrb_pkg::SEED_BITS-1:0] seed_q;
	logic [lrb_pkg::IVL_BITS-1:0]  cap_q;
	logic [lrb_pkg::IVL_BITS-1:0]  close_to_q;
	logic                          cfg_wr;
	lrb_pkg::cfg_idx_t             cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = lrb_pkg::cfg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= lrb_pkg::SEED_RST;
			cap_q      <= lrb_pkg::CAP_RST;
			close_to_q <= lrb_pkg::CLOSE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				lrb_pkg::CFG_SEED:  seed_q     <= pwdata[lrb_pkg::SEED_BITS-1:0];
				lrb_pkg::CFG_CAP:   cap_q      <= pwdata[lrb_pkg::IVL_BITS-1:0];
				lrb_pkg::CFG_CLOSE: close_to_q <= pwdata[lrb_pkg::IVL_BITS-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (cfg_idx)
			lrb_pkg::CFG_SEED:  prdata = lrb_pkg::DATA_BITS'(seed_q);
			lrb_pkg::CFG_CAP:   prdata = lrb_pkg::DATA_BITS'(cap_q);
			lrb_pkg::CFG_CLOSE: prdata = lrb_pkg::DATA_BITS'(close_to_q);
			default:            prdata = '0;
		endcase
	end

	// ---------------- handshake and input register ----------------
	logic          s1_valid;
	lrb_pkg::req_t req_s1;
	logic          rsp_valid_q;
	lrb_pkg::rsp_t rsp_q;
	logic          adv_out;   // result register can load this cycle
	logic          fire;      // event in the input register is executed

	assign adv_out   = !rsp_valid_q || rsp_ready;
	assign fire      = s1_valid && adv_out;
	assign req_ready = !s1_valid || adv_out;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req_ready) begin
			s1_valid <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// ---------------- supervisor state ----------------
	lrb_pkg::state_t              state_q, state_d;
	logic [TIME_BITS-1:0]         link_stamp_q, link_stamp_d;
	logic [TIME_BITS-1:0]         sess_stamp_q, sess_stamp_d;
	logic [lrb_pkg::IVL_BITS-1:0] ivl_q, ivl_d;
	logic                         clean_q, clean_d;

	// decoded event
	logic [TIME_BITS-1:0] now_t;
	logic                 is_poll;
	logic                 lost;       // poll sees link down outside join / wait link
	lrb_pkg::state_t      eff_state;  // state after link-loss handling
	logic [TIME_BITS-1:0] el_link;
	logic [TIME_BITS-1:0] el_sess;
	logic                 link_due;   // link retry interval passed (never on a link-loss poll)
	logic                 sess_due;   // session retry interval passed
	logic                 force_due;  // graceful close timed out

	assign now_t     = TIME_BITS'(req_s1.now_ms);
	assign is_poll   = (req_s1.opcode == lrb_pkg::OP_POLL);
	assign lost      = is_poll && !req_s1.link_up
	                   && (state_q != lrb_pkg::ST_JOIN) && (state_q != lrb_pkg::ST_WAIT_LINK);
	assign eff_state = lost ? lrb_pkg::ST_JOIN : state_q;

	// wrapping elapsed times
	assign el_link   = now_t - link_stamp_q;
	assign el_sess   = now_t - sess_stamp_q;
	// after link loss the fresh stamp gives zero elapsed, never past a zero interval
	assign link_due  = !lost && (CMP_BITS'(el_link) > CMP_BITS'(ivl_q));
	assign sess_due  = CMP_BITS'(el_sess) > CMP_BITS'(ivl_q);
	assign force_due = CMP_BITS'(el_sess) > CMP_BITS'(close_to_q);

	// backoff: seed when zero, double, clamp to cap
	logic [lrb_pkg::IVL_BITS-1:0] bo_base;
	logic [lrb_pkg::IVL_BITS:0]   bo_dbl;
	logic [lrb_pkg::IVL_BITS-1:0] bo_next;

	assign bo_base = (ivl_q == '0) ? lrb_pkg::IVL_BITS'(seed_q) : ivl_q;
	assign bo_dbl  = {bo_base, 1'b0};
	assign bo_next = (bo_dbl > (lrb_pkg::IVL_BITS+1)'(cap_q)) ? cap_q
	                 : bo_dbl[lrb_pkg::IVL_BITS-1:0];

	// next state and stored values
	always_comb begin
		state_d      = state_q;
		link_stamp_d = link_stamp_q;
		sess_stamp_d = sess_stamp_q;
		ivl_d        = ivl_q;
		clean_d      = clean_q;
		case (req_s1.opcode)
			lrb_pkg::OP_POLL: begin
				if (lost) begin
					state_d      = lrb_pkg::ST_JOIN;
					link_stamp_d = now_t;
					ivl_d        = '0;
				end
				unique case (eff_state)
					lrb_pkg::ST_JOIN: begin
						if (link_due) begin
							if (req_s1.join_ok) begin
								state_d = lrb_pkg::ST_WAIT_LINK;
							end
							link_stamp_d = now_t;
							ivl_d        = bo_next;
						end
					end
					lrb_pkg::ST_WAIT_LINK: begin
						if (req_s1.link_up) begin
							state_d      = lrb_pkg::ST_CONNECT;
							sess_stamp_d = now_t;
							ivl_d        = '0;
						end else if (link_due) begin
							state_d = lrb_pkg::ST_JOIN;
						end
					end
					lrb_pkg::ST_CONNECT: begin
						if (sess_due && req_s1.connect_ok) begin
							state_d = lrb_pkg::ST_WAIT_SESSION;
						end
					end
					lrb_pkg::ST_SETUP: begin
						// setup hook finishes at once
						clean_d = 1'b0;
						state_d = lrb_pkg::ST_CONNECTED;
					end
					default: ;
				endcase
			end
			lrb_pkg::OP_START: begin
				state_d      = lrb_pkg::ST_JOIN;
				link_stamp_d = now_t;
				ivl_d        = '0;
			end
			lrb_pkg::OP_SESS_UP: begin
				ivl_d = '0;
				if (state_q == lrb_pkg::ST_WAIT_SESSION) begin
					state_d = req_s1.session_present ? lrb_pkg::ST_CONNECTED
					                                 : lrb_pkg::ST_SETUP;
				end
			end
			lrb_pkg::OP_SESS_DROP: begin
				sess_stamp_d = now_t;
				if (state_q == lrb_pkg::ST_CLOSING) begin
					state_d = lrb_pkg::ST_CLOSED;
				end else begin
					ivl_d   = bo_next;
					state_d = lrb_pkg::ST_CONNECT;
				end
			end
			lrb_pkg::OP_CLOSE_REQ: begin
				if (state_q == lrb_pkg::ST_CONNECTED) begin
					state_d      = lrb_pkg::ST_CLOSING;
					sess_stamp_d = now_t;
				end
			end
			default: ;  // unknown opcode leaves everything as is
		endcase
	end

	// strobes and notify for this event
	logic            do_join, do_connect, do_graceful, do_force, accepted;
	lrb_pkg::notify_t notify;

	always_comb begin
		do_join     = 1'b0;
		do_connect  = 1'b0;
		do_graceful = 1'b0;
		do_force    = 1'b0;
		accepted    = 1'b0;
		notify      = lrb_pkg::NTF_NONE;
		case (req_s1.opcode)
			lrb_pkg::OP_POLL: begin
				if (lost) begin
					notify = lrb_pkg::NTF_LINK_LOST;
				end
				unique case (eff_state)
					lrb_pkg::ST_JOIN:      do_join = link_due;
					lrb_pkg::ST_WAIT_LINK: begin
						if (req_s1.link_up) begin
							notify = lrb_pkg::NTF_LINK_UP;
						end
					end
					lrb_pkg::ST_CONNECT:   do_connect = sess_due;
					lrb_pkg::ST_SETUP:     notify = lrb_pkg::NTF_SESSION_UP;
					lrb_pkg::ST_CLOSING:   do_force = force_due;
					default: ;
				endcase
			end
			lrb_pkg::OP_SESS_UP: begin
				if (state_q == lrb_pkg::ST_WAIT_SESSION && req_s1.session_present) begin
					notify = lrb_pkg::NTF_SESSION_UP;
				end
			end
			lrb_pkg::OP_SESS_DROP: begin
				notify = (state_q == lrb_pkg::ST_CLOSING) ? lrb_pkg::NTF_CLOSED
				                                           : lrb_pkg::NTF_SESSION_LOST;
			end
			lrb_pkg::OP_CLOSE_REQ: begin
				if (state_q == lrb_pkg::ST_CONNECTED) begin
					do_graceful = 1'b1;
					accepted    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// state registers update only when an event executes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lrb_pkg::ST_OFFLINE;
			link_stamp_q <= '0;
			sess_stamp_q <= '0;
			ivl_q        <= '0;
			clean_q      <= 1'b1;
		end else if (fire) begin
			state_q      <= state_d;
			link_stamp_q <= link_stamp_d;
			sess_stamp_q <= sess_stamp_d;
			ivl_q        <= ivl_d;
			clean_q      <= clean_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_out) begin
			rsp_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.state_code        <= state_d;
			rsp_q.is_connected      <= (state_d == lrb_pkg::ST_CONNECTED);
			rsp_q.do_join           <= do_join;
			rsp_q.do_connect        <= do_connect;
			rsp_q.do_graceful_close <= do_graceful;
			rsp_q.do_force_close    <= do_force;
			rsp_q.notify            <= notify;
			rsp_q.accepted          <= accepted;
			rsp_q.clean_start       <= clean_d;
		end
	end

	// ---------------- assertions ----------------
	// supervisor state moves only when an event executes
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q))
		else $error("state changed without an executed event");

	// a forced close is only issued while closing
	a_force_closing: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.do_force_close) |-> (rsp.state_code == lrb_pkg::ST_CLOSING))
		else $error("forced close outside closing");

	// an accepted close request issues the graceful close and enters closing
	a_accept_close: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.accepted) |->
		(rsp.do_graceful_close && rsp.state_code == lrb_pkg::ST_CLOSING))
		else $error("accepted close without graceful close");

	// session up notify always lands in connected
	a_session_up: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.notify == lrb_pkg::NTF_SESSION_UP) |-> rsp.is_connected)
		else $error("session up reported outside connected");

	// an executed event always lands in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("executed event produced no result");

endmodule

`default_nettype wire
